// File: rtl/hmm_pkg.sv
// Shared types and constants for the hexacopter motor mixer.
package hmm_pkg;

	localparam int MOTOR_COUNT = 6;
	localparam int CMD_W       = 12;
	localparam int MIX_W       = 18;
	localparam int ADDR_W      = 4;
	localparam int DATA_W      = 32;

	// mixing coefficients in ten-thousandths
	localparam int COEF_C_TENK = 1667;
	localparam int COEF_A_TENK = 2887;
	localparam int COEF_D_TENK = 3333;

	localparam logic [CMD_W-1:0] MIN_CMD_RESET   = 12'd1100;
	localparam logic [CMD_W-1:0] MAX_CMD_RESET   = 12'd1950;
	localparam logic [CMD_W-1:0] LOW_STICK_RESET = 12'd1150;
	localparam logic [CMD_W-1:0] IDLE_CMD_RESET  = 12'd1000;

	typedef enum logic [1:0] {
		REG_MIN_CMD   = 2'd0,
		REG_MAX_CMD   = 2'd1,
		REG_LOW_STICK = 2'd2,
		REG_IDLE_CMD  = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [CMD_W-1:0] min_command;
		logic [CMD_W-1:0] max_command;
		logic [CMD_W-1:0] low_stick_level;
		logic [CMD_W-1:0] idle_command;
	} cfg_t;

	typedef struct packed {
		logic        [15:0] throttle_in;
		logic signed [15:0] roll_term;
		logic signed [15:0] pitch_term;
		logic signed [15:0] yaw_term;
		logic               armed;
		logic               alt_hold;
		logic        [11:0] stick_throttle;
	} in_item_t;

	typedef struct packed {
		logic [CMD_W-1:0] motor_a;
		logic [CMD_W-1:0] motor_b;
		logic [CMD_W-1:0] motor_c;
		logic [CMD_W-1:0] motor_d;
		logic [CMD_W-1:0] motor_e;
		logic [CMD_W-1:0] motor_f;
	} out_item_t;

	// truncated mixes handed from front to back
	typedef struct packed {
		logic                                idle;
		logic [MOTOR_COUNT-1:0][MIX_W-1:0]   motor;
	} mix_item_t;

endpackage

// File: rtl/hmm_fifo.sv
// Small register FIFO used between pipeline sections.
module hmm_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic [WIDTH-1:0] wdata,
	output logic             empty,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

// File: rtl/hmm_front.sv
// Front section: accepts items, flags idle override, multiplies, sums, truncates.
module hmm_front #(
	parameter int COEF_FRAC_BITS = 14
) (
	input  logic                clk,
	input  logic                arst_n,
	input  hmm_pkg::cfg_t       cfg,
	input  logic                push,
	output logic                full,
	input  hmm_pkg::in_item_t   item,
	output logic                mix_valid,
	input  logic                mix_full,
	output hmm_pkg::mix_item_t  mix_item
);

	localparam int F      = COEF_FRAC_BITS;
	localparam int COEF_W = F + 2;
	localparam int PROD_W = COEF_W + 17;
	localparam int SUM_W  = PROD_W + 2;
	localparam int MC     = hmm_pkg::MOTOR_COUNT;
	localparam int MIX_W  = hmm_pkg::MIX_W;

	localparam int KC = ((hmm_pkg::COEF_C_TENK << F) + 5000) / 10000;
	localparam int KA = ((hmm_pkg::COEF_A_TENK << F) + 5000) / 10000;
	localparam int KD = ((hmm_pkg::COEF_D_TENK << F) + 5000) / 10000;

	localparam logic signed [COEF_W-1:0] KC_S = COEF_W'(KC);
	localparam logic signed [COEF_W-1:0] KA_S = COEF_W'(KA);
	localparam logic signed [COEF_W-1:0] KD_S = COEF_W'(KD);

	logic en_s1, en_s2, en_s3;
	logic valid_s1, valid_s2, valid_s3;
	logic idle_s1, idle_s2, idle_s3;

	logic signed [PROD_W-1:0] pt_s1, pr_s1, pp_s1, py_s1, pd_s1;
	logic signed [SUM_W-1:0]  sum_s2 [MC];
	logic [MC-1:0][MIX_W-1:0] mix_s3;

	logic signed [SUM_W-1:0] pt_x, pr_x, pd_x, pq_x;
	logic signed [SUM_W-1:0] biased [MC];
	logic signed [SUM_W-1:0] shifted [MC];

	assign en_s3 = !valid_s3 || !mix_full;
	assign en_s2 = !valid_s2 || en_s3;
	assign en_s1 = !valid_s1 || en_s2;
	assign full  = !en_s1;

	assign pt_x = SUM_W'(pt_s1);
	assign pr_x = SUM_W'(pr_s1);
	assign pd_x = SUM_W'(pd_s1);
	assign pq_x = SUM_W'(pp_s1) + SUM_W'(py_s1);

	always_comb begin
		for (int i = 0; i < MC; i++) begin
			biased[i]  = sum_s2[i]
				+ $signed({{(SUM_W-F){1'b0}}, {F{sum_s2[i][SUM_W-1]}}});
			shifted[i] = biased[i] >>> F;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (en_s1) begin
				valid_s1 <= push;
			end
			if (en_s2) begin
				valid_s2 <= valid_s1;
			end
			if (en_s3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && push) begin
			pt_s1   <= PROD_W'($signed({1'b0, item.throttle_in}) * KC_S);
			pr_s1   <= PROD_W'(item.roll_term * KA_S);
			pp_s1   <= PROD_W'(item.pitch_term * KC_S);
			py_s1   <= PROD_W'(item.yaw_term * KC_S);
			pd_s1   <= PROD_W'(item.pitch_term * KD_S);
			idle_s1 <= !item.armed
				|| (!item.alt_hold && (item.stick_throttle < cfg.low_stick_level));
		end
		if (en_s2 && valid_s1) begin
			sum_s2[0] <= pt_x + pr_x - pq_x;
			sum_s2[1] <= pt_x - pd_x + SUM_W'(py_s1);
			sum_s2[2] <= pt_x - pr_x - pq_x;
			sum_s2[3] <= pt_x - pr_x + pq_x;
			sum_s2[4] <= pt_x + pd_x - SUM_W'(py_s1);
			sum_s2[5] <= pt_x + pr_x + pq_x;
			idle_s2   <= idle_s1;
		end
		if (en_s3 && valid_s2) begin
			for (int i = 0; i < MC; i++) begin
				mix_s3[i] <= shifted[i][MIX_W-1:0];
			end
			idle_s3 <= idle_s2;
		end
	end

	assign mix_valid      = valid_s3;
	assign mix_item.idle  = idle_s3;
	assign mix_item.motor = mix_s3;

endmodule

// File: rtl/hmm_back.sv
// Back section: largest mix, shift-down, clamp and idle override.
module hmm_back (
	input  logic                clk,
	input  logic                arst_n,
	input  hmm_pkg::cfg_t       cfg,
	input  logic                mix_empty,
	output logic                mix_pop,
	input  hmm_pkg::mix_item_t  mix_item,
	output logic                res_push,
	input  logic                res_full,
	output hmm_pkg::out_item_t  res_item
);

	localparam int MC    = hmm_pkg::MOTOR_COUNT;
	localparam int MIX_W = hmm_pkg::MIX_W;
	localparam int CMD_W = hmm_pkg::CMD_W;
	localparam int VW    = MIX_W + 2;

	logic en_s1, en_s2, en_s3;
	logic valid_s1, valid_s2, valid_s3;
	logic idle_s1, idle_s2;

	logic signed [MIX_W-1:0] mix_s1 [MC];
	logic signed [MIX_W-1:0] top_s1;
	logic signed [VW-1:0]    val_s2 [MC];
	logic [CMD_W-1:0]        cmd_s3 [MC];

	logic signed [MIX_W-1:0] m_in [MC];
	logic signed [MIX_W-1:0] max01, max23, max45, max03, top_c;
	logic signed [VW-1:0]    hi_x, lo_x, excess;
	logic                    over;
	logic signed [VW-1:0]    lo_c [MC];
	logic [CMD_W-1:0]        cmd_c [MC];

	assign en_s3    = !valid_s3 || !res_full;
	assign en_s2    = !valid_s2 || en_s3;
	assign en_s1    = !valid_s1 || en_s2;
	assign mix_pop  = en_s1 && !mix_empty;
	assign res_push = valid_s3;

	always_comb begin
		for (int i = 0; i < MC; i++) begin
			m_in[i] = $signed(mix_item.motor[i]);
		end
		max01 = (m_in[1] > m_in[0]) ? m_in[1] : m_in[0];
		max23 = (m_in[3] > m_in[2]) ? m_in[3] : m_in[2];
		max45 = (m_in[5] > m_in[4]) ? m_in[5] : m_in[4];
		max03 = (max23 > max01) ? max23 : max01;
		top_c = (max45 > max03) ? max45 : max03;
	end

	assign hi_x   = $signed({{(VW-CMD_W){1'b0}}, cfg.max_command});
	assign lo_x   = $signed({{(VW-CMD_W){1'b0}}, cfg.min_command});
	assign over   = VW'(top_s1) > hi_x;
	assign excess = over ? (VW'(top_s1) - hi_x) : '0;

	always_comb begin
		for (int i = 0; i < MC; i++) begin
			lo_c[i] = (val_s2[i] < lo_x) ? lo_x : val_s2[i];
			if (idle_s2) begin
				cmd_c[i] = cfg.idle_command;
			end else if (lo_c[i] > hi_x) begin
				cmd_c[i] = cfg.max_command;
			end else begin
				cmd_c[i] = lo_c[i][CMD_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (en_s1) begin
				valid_s1 <= !mix_empty;
			end
			if (en_s2) begin
				valid_s2 <= valid_s1;
			end
			if (en_s3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mix_pop) begin
			mix_s1  <= m_in;
			top_s1  <= top_c;
			idle_s1 <= mix_item.idle;
		end
		if (en_s2 && valid_s1) begin
			for (int i = 0; i < MC; i++) begin
				val_s2[i] <= VW'(mix_s1[i]) - excess;
			end
			idle_s2 <= idle_s1;
		end
		if (en_s3 && valid_s2) begin
			cmd_s3 <= cmd_c;
		end
	end

	assign res_item.motor_a = cmd_s3[0];
	assign res_item.motor_b = cmd_s3[1];
	assign res_item.motor_c = cmd_s3[2];
	assign res_item.motor_d = cmd_s3[3];
	assign res_item.motor_e = cmd_s3[4];
	assign res_item.motor_f = cmd_s3[5];

endmodule

// File: rtl/hexacopter_motor_mixer_top.sv
// Top level of the hexacopter motor mixer: config registers, sections and queues.
//
// Input channel: present an item on "item" with push high; it is taken at a
// rising edge where full is low. One item can be taken every cycle while full stays low.
// Result channel: while empty is low the oldest result sits on "result";
// raise pop to take it. Each item yields exactly one result, in order.
// Path: a taken item passes through three front stages, the middle queue, three
// back stages and the result queue before it shows on the result ports.
// Throughput: one item per cycle while no stall holds the stages on either side.
// Stalls: when pop is held low the result queue fills, the back stages hold,
// the 4-entry middle queue fills and then full rises; items already taken are
// never lost.
// Configuration: APB writes at byte addresses 0, 4, 8, 12 set min_command,
// max_command, low_stick_level and idle_command; write only while idle.
// Reset (arst_n low) empties every stage and queue and loads the register
// defaults 1100, 1950, 1150 and 1000.
module hexacopter_motor_mixer_top #(
	parameter int COEF_FRAC_BITS = 14
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	output logic                         full,
	input  hmm_pkg::in_item_t            item,
	output logic                         empty,
	input  logic                         pop,
	output hmm_pkg::out_item_t           result,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [hmm_pkg::ADDR_W-1:0]   paddr,
	input  logic [hmm_pkg::DATA_W-1:0]   pwdata,
	output logic [hmm_pkg::DATA_W-1:0]   prdata,
	output logic                         pready
);

	localparam int CMD_W = hmm_pkg::CMD_W;

	hmm_pkg::cfg_t      cfg_q;
	hmm_pkg::reg_idx_t  reg_idx;
	logic               cfg_wr;
	logic [CMD_W-1:0]   rd_val;

	logic               front_valid;
	logic               mid_full;
	logic               mid_empty;
	logic               mid_pop;
	hmm_pkg::mix_item_t front_item;
	hmm_pkg::mix_item_t mid_item;
	logic               res_push;
	logic               res_full;
	hmm_pkg::out_item_t res_item;

	assign pready  = 1'b1;
	assign reg_idx = hmm_pkg::reg_idx_t'(paddr[3:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_command     <= hmm_pkg::MIN_CMD_RESET;
			cfg_q.max_command     <= hmm_pkg::MAX_CMD_RESET;
			cfg_q.low_stick_level <= hmm_pkg::LOW_STICK_RESET;
			cfg_q.idle_command    <= hmm_pkg::IDLE_CMD_RESET;
		end else if (cfg_wr) begin
			case (reg_idx)
				hmm_pkg::REG_MIN_CMD:   cfg_q.min_command     <= pwdata[CMD_W-1:0];
				hmm_pkg::REG_MAX_CMD:   cfg_q.max_command     <= pwdata[CMD_W-1:0];
				hmm_pkg::REG_LOW_STICK: cfg_q.low_stick_level <= pwdata[CMD_W-1:0];
				hmm_pkg::REG_IDLE_CMD:  cfg_q.idle_command    <= pwdata[CMD_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			hmm_pkg::REG_MIN_CMD:   rd_val = cfg_q.min_command;
			hmm_pkg::REG_MAX_CMD:   rd_val = cfg_q.max_command;
			hmm_pkg::REG_LOW_STICK: rd_val = cfg_q.low_stick_level;
			hmm_pkg::REG_IDLE_CMD:  rd_val = cfg_q.idle_command;
			default:                rd_val = '0;
		endcase
	end

	assign prdata = {{(hmm_pkg::DATA_W-CMD_W){1'b0}}, rd_val};

	hmm_front #(
		.COEF_FRAC_BITS(COEF_FRAC_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.push      (push),
		.full      (full),
		.item      (item),
		.mix_valid (front_valid),
		.mix_full  (mid_full),
		.mix_item  (front_item)
	);

	hmm_fifo #(
		.WIDTH($bits(hmm_pkg::mix_item_t)),
		.DEPTH(4)
	) u_mid_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (front_valid),
		.full   (mid_full),
		.wdata  (front_item),
		.empty  (mid_empty),
		.pop    (mid_pop),
		.rdata  (mid_item)
	);

	hmm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.mix_empty (mid_empty),
		.mix_pop   (mid_pop),
		.mix_item  (mid_item),
		.res_push  (res_push),
		.res_full  (res_full),
		.res_item  (res_item)
	);

	hmm_fifo #(
		.WIDTH($bits(hmm_pkg::out_item_t)),
		.DEPTH(2)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.full   (res_full),
		.wdata  (res_item),
		.empty  (empty),
		.pop    (pop),
		.rdata  (result)
	);

	logic motors_ok;

	always_comb begin
		motors_ok = 1'b1;
		for (int i = 0; i < hmm_pkg::MOTOR_COUNT; i++) begin
			if (result[i*CMD_W +: CMD_W] > cfg_q.max_command
				&& result[i*CMD_W +: CMD_W] != cfg_q.idle_command) begin
				motors_ok = 1'b0;
			end
		end
	end

	// every waiting command is within the upper limit or is the idle value
	a_motor_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> motors_ok)
		else $error("motor command above upper limit");

	// the front stalls only when the middle queue is backed up
	a_full_cause: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> mid_full)
		else $error("full raised with room in middle queue");

	// a result written into the result queue leaves it non-empty next cycle
	a_back_feed: assert property (@(posedge clk) disable iff (!arst_n)
		res_push && !res_full |=> !empty)
		else $error("result queue empty after a result was written");

endmodule
